[hw/rtl/bir_pkg.sv]
// Package for the bilinear image rescaler: constants, types and state encodings.
// No dependencies.
`timescale 1ns / 1ps
package bir_pkg;
  localparam int FracBits = 16;
  localparam int AddrW = 16;
  localparam int QuotW = 34;
  localparam int NumW = 34;

  localparam logic [1:0] RegSrcW = 2'd0;
  localparam logic [1:0] RegSrcH = 2'd1;
  localparam logic [1:0] RegDstW = 2'd2;
  localparam logic [1:0] RegDstH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_ADDR, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_WGT, ST_MAC, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic start_mul;
    logic start_div;
    logic div_step;
    logic calc_addr;
    logic [1:0] rd_sel;
    logic rd_en;
    logic calc_wgt;
    logic mac;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } status_t;
endpackage

[hw/rtl/bir_if.sv]
// Valid/ready channel interface for items of the rescaler.
// Depends on nothing.
`timescale 1ns / 1ps
interface bir_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [7:0] pixel_c0;
  logic [7:0] pixel_c1;
  logic [7:0] pixel_c2;
  logic [9:0] dst_x;
  logic [9:0] dst_y;
  modport source(output valid, action, pixel_c0, pixel_c1, pixel_c2, dst_x, dst_y, input ready);
  modport sink(input valid, action, pixel_c0, pixel_c1, pixel_c2, dst_x, dst_y, output ready);
endinterface

interface bir_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_c0;
  logic [7:0] out_c1;
  logic [7:0] out_c2;
  modport source(output valid, out_c0, out_c1, out_c2, input ready);
  modport sink(input valid, out_c0, out_c1, out_c2, output ready);
endinterface

[hw/rtl/bir_ctrl.sv]
// Controller state machine of the rescaler.
// Depends on bir_pkg.
`timescale 1ns / 1ps
module bir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  input  bir_pkg::status_t  status_i,
  output bir_pkg::cmd_t     cmd_o
);
  import bir_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && in_action_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (status_i.div_done) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_WGT;
      ST_WGT:  state_d = ST_MAC;
      ST_MAC:  state_d = ST_OUT;
      ST_OUT:  if (!status_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i && !in_action_i;
        cmd_o.start_mul = in_valid_i && in_action_i;
      end
      ST_MUL:  cmd_o.start_div = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_ADDR: cmd_o.calc_addr = 1'b1;
      ST_RD0: begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd0; end
      ST_RD1: begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd1; end
      ST_RD2: begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd2; end
      ST_RD3: begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd3; end
      ST_WGT:  cmd_o.calc_wgt = 1'b1;
      ST_MAC:  cmd_o.mac = 1'b1;
      ST_OUT:  cmd_o.out_load = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end
endmodule

[hw/rtl/bir_datapath.sv]
// Datapath of the rescaler: frame memory, coordinate dividers, weights and blend.
// Depends on bir_pkg.
`timescale 1ns / 1ps
module bir_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bir_pkg::cmd_t     cmd_i,
  output bir_pkg::status_t  status_o,
  input  logic [7:0]        pixel_c0_i,
  input  logic [7:0]        pixel_c1_i,
  input  logic [7:0]        pixel_c2_i,
  input  logic [9:0]        dst_x_i,
  input  logic [9:0]        dst_y_i,
  input  logic [8:0]        src_w_i,
  input  logic [8:0]        src_h_i,
  input  logic [10:0]       dst_w_i,
  input  logic [10:0]       dst_h_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_c0_o,
  output logic [7:0]        out_c1_o,
  output logic [7:0]        out_c2_o
);
  import bir_pkg::*;

  logic [23:0] mem_q [2**AddrW];
  logic [23:0] rd_q;
  logic [AddrW-1:0] load_q, rd_addr;
  logic [8:0] sw, sh;
  logic [10:0] dw, dh;
  logic [16:0] area;

  assign sw = (src_w_i == '0) ? 9'd1 : ((src_w_i > 9'd256) ? 9'd256 : src_w_i);
  assign sh = (src_h_i == '0) ? 9'd1 : ((src_h_i > 9'd256) ? 9'd256 : src_h_i);
  assign dw = (dst_w_i == '0) ? 11'd1 : dst_w_i;
  assign dh = (dst_h_i == '0) ? 11'd1 : dst_h_i;
  assign area = 17'(sw * sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else if (cmd_i.load) begin
      load_q <= ({1'b0, load_q} + 17'd1 >= area) ? '0 : load_q + 1'b1;
    end
  end

  // Numerators are (d*S) << F, divided by restoring division one bit a cycle.
  logic [NumW-1:0] numx_q, numy_q;
  logic [QuotW-1:0] qx_q, qy_q;
  logic [11:0] rx_q, ry_q;
  logic [5:0] cnt_q;
  logic [11:0] rx_t, ry_t;
  logic [12:0] rx_s, ry_s;

  assign rx_t = {rx_q[10:0], numx_q[NumW-1]};
  assign ry_t = {ry_q[10:0], numy_q[NumW-1]};
  assign rx_s = {1'b0, rx_t} - {2'b0, dw};
  assign ry_s = {1'b0, ry_t} - {2'b0, dh};
  assign status_o.div_done = (cnt_q == 6'd1) && cmd_i.div_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start_div) begin
      cnt_q <= 6'(NumW);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_mul) begin
      numx_q <= {19'(dst_x_i * sw), 15'b0} << 1;
      numy_q <= {19'(dst_y_i * sh), 15'b0} << 1;
    end
    if (cmd_i.start_div) begin
      rx_q <= '0; ry_q <= '0; qx_q <= '0; qy_q <= '0;
    end else if (cmd_i.div_step) begin
      numx_q <= numx_q << 1;
      numy_q <= numy_q << 1;
      rx_q <= rx_s[12] ? rx_t : rx_s[11:0];
      ry_q <= ry_s[12] ? ry_t : ry_s[11:0];
      qx_q <= {qx_q[QuotW-2:0], ~rx_s[12]};
      qy_q <= {qy_q[QuotW-2:0], ~ry_s[12]};
    end
  end

  logic [7:0] x0_q, x1_q, y0_q, y1_q;
  logic [FracBits-1:0] fx_q, fy_q;
  logic [QuotW-FracBits-1:0] ix, iy;
  logic [8:0] lx, ly;
  assign ix = qx_q[QuotW-1:FracBits];
  assign iy = qy_q[QuotW-1:FracBits];
  assign lx = sw - 9'd1;
  assign ly = sh - 9'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_addr) begin
      fx_q <= qx_q[FracBits-1:0];
      fy_q <= qy_q[FracBits-1:0];
      if (ix >= (QuotW-FracBits)'(lx)) begin
        x0_q <= lx[7:0]; x1_q <= lx[7:0];
      end else begin
        x0_q <= ix[7:0]; x1_q <= ix[7:0] + 8'd1;
      end
      if (iy >= (QuotW-FracBits)'(ly)) begin
        y0_q <= ly[7:0]; y1_q <= ly[7:0];
      end else begin
        y0_q <= iy[7:0]; y1_q <= iy[7:0] + 8'd1;
      end
    end
  end

  logic [7:0] ysel, xsel;
  assign ysel = cmd_i.rd_sel[1] ? y1_q : y0_q;
  assign xsel = cmd_i.rd_sel[0] ? x1_q : x0_q;
  assign rd_addr = AddrW'(ysel * sw + {8'b0, xsel});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem_q[load_q] <= {pixel_c2_i, pixel_c1_i, pixel_c0_i};
    if (cmd_i.rd_en) rd_q <= mem_q[rd_addr];
  end

  // Pixel read in one state lands in rd_q in the next cycle; capture in order.
  logic [23:0] p_q [4];
  logic [1:0] cap_q;
  logic cap_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_v_q <= 1'b0;
      cap_q <= '0;
    end else begin
      cap_v_q <= cmd_i.rd_en;
      cap_q <= cmd_i.rd_sel;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cap_v_q) p_q[cap_q] <= rd_q;
  end

  logic [16:0] gx, gy;
  logic [33:0] w_q [4];
  assign gx = 17'h10000 - {1'b0, fx_q};
  assign gy = 17'h10000 - {1'b0, fy_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_wgt) begin
      w_q[0] <= gx * gy;
      w_q[1] <= {1'b0, fx_q} * gy;
      w_q[2] <= gx * {1'b0, fy_q};
      w_q[3] <= {1'b0, fx_q} * {1'b0, fy_q};
    end
  end

  logic [41:0] acc [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = 42'(p_q[0][8*c +: 8] * w_q[0]) + 42'(p_q[1][8*c +: 8] * w_q[1])
             + 42'(p_q[2][8*c +: 8] * w_q[2]) + 42'(p_q[3][8*c +: 8] * w_q[3]);
    end
  end

  logic [23:0] res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac) res_q <= {acc[2][39:32], acc[1][39:32], acc[0][39:32]};
  end

  logic ov_q;
  logic [23:0] ob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) ob_q <= res_q;
  end

  assign status_o.out_busy = ov_q && !out_ready_i;
  assign out_valid_o = ov_q;
  assign out_c0_o = ob_q[7:0];
  assign out_c1_o = ob_q[15:8];
  assign out_c2_o = ob_q[23:16];
endmodule

[hw/rtl/bilinear_image_rescaler_core.sv]
// Top level of the bilinear image rescaler: APB registers, controller, datapath.
// Depends on bir_pkg, bir_if, bir_ctrl and bir_datapath.
//
// Input items arrive on in_if (valid/ready). An item with action 0 writes one
// source pixel into the frame memory in raster order and gives no result. An
// item with action 1 asks for one output pixel, which leaves on out_if.
// After a load item the block stays idle and can accept the next item. No item
// is accepted while a request is in progress, until its result is in the output
// register: two coordinate divisions run one quotient bit a cycle, four neighbor
// reads share the frame memory read port, then the weights and the blend are registered.
// The result sits in an output register; the next item is accepted while it
// waits, and only a second result stalls behind a receiver that holds ready low.
// Reset clears the load counter and sets the size registers to 256, 256, 244
// and 244. The frame memory is not cleared; reading an unwritten pixel is
// undefined. Registers are to be written over APB only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module bilinear_image_rescaler_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  bir_in_if.sink        in_if,
  bir_out_if.source     out_if,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bir_pkg::*;

  logic [8:0] src_w_q, src_h_q;
  logic [10:0] dst_w_q, dst_h_q;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 11'd244;
      dst_h_q <= 11'd244;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegSrcW: src_w_q <= pwdata[8:0];
        RegSrcH: src_h_q <= pwdata[8:0];
        RegDstW: dst_w_q <= pwdata[10:0];
        RegDstH: dst_h_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSrcW: prdata = {23'b0, src_w_q};
      RegSrcH: prdata = {23'b0, src_h_q};
      RegDstW: prdata = {21'b0, dst_w_q};
      RegDstH: prdata = {21'b0, dst_h_q};
      default: prdata = '0;
    endcase
  end

  cmd_t cmd;
  status_t status;

  bir_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_action_i(in_if.action), .in_ready_o(in_if.ready),
    .status_i(status), .cmd_o(cmd)
  );

  bir_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .pixel_c0_i(in_if.pixel_c0), .pixel_c1_i(in_if.pixel_c1), .pixel_c2_i(in_if.pixel_c2),
    .dst_x_i(in_if.dst_x), .dst_y_i(in_if.dst_y),
    .src_w_i(src_w_q), .src_h_i(src_h_q), .dst_w_i(dst_w_q), .dst_h_i(dst_h_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_c0_o(out_if.out_c0), .out_c1_o(out_if.out_c1), .out_c2_o(out_if.out_c2)
  );
endmodule

[tb/sv/tb_bilinear_image_rescaler_core.sv]
// Self-checking testbench for bilinear_image_rescaler_core: loads source pixels, requests
// interpolated pixels under random idling and back-pressure, checks every result in order.
// Depends on bir_pkg, bir_if and the rescaler RTL.
`timescale 1ns / 1ps
module tb_bilinear_image_rescaler_core;
  import bir_pkg::*;

  typedef struct {
    bit       action;
    bit [7:0] c0, c1, c2;
    bit [9:0] x, y;
  } pix_item_t;

  localparam bit ACT_LOAD = 1'b0;
  localparam bit ACT_REQ = 1'b1;
  localparam int FRAME_DEPTH = 65536;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  bir_in_if in_ch();
  bir_out_if out_ch();

  bilinear_image_rescaler_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch), .out_if(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pix_item_t pending_items[$];
  bit [23:0] expected_pixels[$];
  bit [23:0] frame_mirror[FRAME_DEPTH];
  bit loaded[FRAME_DEPTH];
  bit [15:0] load_ptr;
  bit [15:0] plan_ptr;
  bit [8:0] src_w_reg, src_h_reg;
  bit [10:0] dst_w_reg, dst_h_reg;
  int errors, n_loads, n_requests, n_results, n_phases;
  int hold_cycles;
  bit hold_go, hold_seen;
  bit no_idle;
  bit in_taken;
  longint cycles;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int eff_src(bit [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic void map_axis(input int d, input int s, input int dn,
                                   output int lo, output int hi, output longint frac);
    longint pos;
    longint idx;
    pos = ((longint'(d) * s) << FracBits) / dn;
    idx = pos >> FracBits;
    frac = pos & ((longint'(1) << FracBits) - 1);
    if (idx >= s - 1) begin
      lo = s - 1;
      hi = s - 1;
    end else begin
      lo = int'(idx);
      hi = int'(idx) + 1;
    end
  endfunction

  function automatic bit [23:0] blend_pixel(bit [9:0] x, bit [9:0] y);
    int sw, sh, dw, dh, x0, x1, y0, y1;
    longint fx, fy, one, acc;
    longint w[4];
    bit [23:0] p[4];
    bit [23:0] res;
    sw = eff_src(src_w_reg);
    sh = eff_src(src_h_reg);
    dw = (dst_w_reg == 0) ? 1 : dst_w_reg;
    dh = (dst_h_reg == 0) ? 1 : dst_h_reg;
    map_axis(x, sw, dw, x0, x1, fx);
    map_axis(y, sh, dh, y0, y1, fy);
    one = longint'(1) << FracBits;
    w[0] = (one - fx) * (one - fy);
    w[1] = fx * (one - fy);
    w[2] = (one - fx) * fy;
    w[3] = fx * fy;
    p[0] = frame_mirror[(y0 * sw + x0) % FRAME_DEPTH];
    p[1] = frame_mirror[(y0 * sw + x1) % FRAME_DEPTH];
    p[2] = frame_mirror[(y1 * sw + x0) % FRAME_DEPTH];
    p[3] = frame_mirror[(y1 * sw + x1) % FRAME_DEPTH];
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += longint'((p[k] >> (8 * c)) & 8'hFF) * w[k];
      res[8*c +: 8] = 8'((acc >> (2 * FracBits)) & 8'hFF);
    end
    return res;
  endfunction

  // A request is only sent when all four neighbors it reads have been loaded.
  function automatic bit reads_loaded(bit [9:0] x, bit [9:0] y);
    int sw, sh, dw, dh, x0, x1, y0, y1;
    longint fx, fy;
    sw = eff_src(src_w_reg);
    sh = eff_src(src_h_reg);
    dw = (dst_w_reg == 0) ? 1 : dst_w_reg;
    dh = (dst_h_reg == 0) ? 1 : dst_h_reg;
    map_axis(x, sw, dw, x0, x1, fx);
    map_axis(y, sh, dh, y0, y1, fy);
    return loaded[y0 * sw + x0] && loaded[y0 * sw + x1] &&
           loaded[y1 * sw + x0] && loaded[y1 * sw + x1];
  endfunction

  // Acceptance of input items updates the predictor; results are checked in order.
  always @(posedge clk_i) begin
    pix_item_t it;
    bit [23:0] got;
    int sw, sh;
    bit taken;
    cycles++;
    taken = 1'b0;
    if (rst_ni && in_ch.valid && in_ch.ready && pending_items.size() > 0) begin
      it = pending_items.pop_front();
      taken = 1'b1;
      if (it.action == ACT_LOAD) begin
        sw = eff_src(src_w_reg);
        sh = eff_src(src_h_reg);
        frame_mirror[load_ptr] = {it.c2, it.c1, it.c0};
        if (int'(load_ptr) + 1 >= sw * sh) load_ptr = 0;
        else load_ptr = load_ptr + 1;
      end else begin
        expected_pixels.insert(expected_pixels.size(), blend_pixel(it.x, it.y));
      end
    end
    in_taken <= taken;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_c2, out_ch.out_c1, out_ch.out_c0};
      n_results++;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        if (got[7:0] != expected_pixels[0][7:0]) begin
          errors++;
          $display("%0t: out_c0 expected %h actual %h", $time, expected_pixels[0][7:0], got[7:0]);
        end
        if (got[15:8] != expected_pixels[0][15:8]) begin
          errors++;
          $display("%0t: out_c1 expected %h actual %h", $time, expected_pixels[0][15:8],
                   got[15:8]);
        end
        if (got[23:16] != expected_pixels[0][23:16]) begin
          errors++;
          $display("%0t: out_c2 expected %h actual %h", $time, expected_pixels[0][23:16],
                   got[23:16]);
        end
        void'(expected_pixels.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    bit offer;
    pix_item_t it;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= ACT_LOAD;
      in_ch.pixel_c0 <= '0;
      in_ch.pixel_c1 <= '0;
      in_ch.pixel_c2 <= '0;
      in_ch.dst_x <= '0;
      in_ch.dst_y <= '0;
    end else if (!in_ch.valid || in_taken) begin
      offer = (pending_items.size() > 0) && (no_idle || $urandom_range(99) >= 30);
      it = (pending_items.size() > 0) ? pending_items[0] : '{default: 0};
      in_ch.valid <= offer;
      in_ch.action <= it.action;
      in_ch.pixel_c0 <= it.c0;
      in_ch.pixel_c1 <= it.c1;
      in_ch.pixel_c2 <= it.c2;
      in_ch.dst_x <= it.x;
      in_ch.dst_y <= it.y;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 500;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 30;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_pixels.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegSrcW: src_w_reg = value[8:0];
      RegSrcH: src_h_reg = value[8:0];
      RegDstW: dst_w_reg = value[10:0];
      default: dst_h_reg = value[10:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    wait_idle();
    reg_write(RegSrcW, sw);
    reg_write(RegSrcH, sh);
    reg_write(RegDstW, dw);
    reg_write(RegDstH, dh);
    n_phases++;
  endtask

  task automatic add_load(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2);
    pix_item_t it;
    int sw, sh;
    it = '{action: ACT_LOAD, c0: c0, c1: c1, c2: c2, x: $urandom, y: $urandom};
    pending_items.insert(pending_items.size(), it);
    loaded[plan_ptr] = 1'b1;
    sw = eff_src(src_w_reg);
    sh = eff_src(src_h_reg);
    if (int'(plan_ptr) + 1 >= sw * sh) plan_ptr = 0;
    else plan_ptr = plan_ptr + 1;
    n_loads++;
  endtask

  task automatic add_request(bit [9:0] x, bit [9:0] y);
    pix_item_t it;
    if (!reads_loaded(x, y)) return;
    it = '{action: ACT_REQ, c0: $urandom, c1: $urandom, c2: $urandom, x: x, y: y};
    pending_items.insert(pending_items.size(), it);
    n_requests++;
  endtask

  function automatic bit [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sw, sh, dw, dh;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_w_reg = 256;
    src_h_reg = 256;
    dst_w_reg = 244;
    dst_h_reg = 244;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // The first three rows of the full-size frame are loaded for the corner requests.
    set_sizes(256, 256, 244, 244);
    for (int i = 0; i < 768; i++) add_load($urandom, $urandom, $urandom);
    add_request(0, 0);
    add_request(243, 1);
    add_request(1023, 0);
    add_request(100, 1);
    set_sizes(256, 2, 1024, 1);
    add_request(1023, 0);
    add_request(511, 700);
    set_sizes(0, 0, 0, 0);
    add_request(0, 0);
    add_request(1023, 1023);
    set_sizes(511, 3, 2047, 1024);
    add_request(1023, 1023);
    add_request(1023, 5);
    set_sizes(3, 2, 7, 5);
    add_load(8'h00, 8'h00, 8'h00);
    add_load(8'hFF, 8'hFF, 8'hFF);
    add_load(8'hFF, 8'h00, 8'hFF);
    for (int i = 0; i < 5; i++) add_request(i, i);
    add_request(6, 4);
    add_request(9, 9);

    for (int ph = 0; ph < 16; ph++) begin
      if ($urandom_range(4) == 0) begin
        sw = $urandom_range(511);
        sh = $urandom_range(511);
        dw = $urandom_range(2047);
        dh = $urandom_range(2047);
      end else begin
        sw = $urandom_range(1, 16);
        sh = $urandom_range(1, 16);
        dw = $urandom_range(1, 40);
        dh = $urandom_range(1, 40);
      end
      set_sizes(sw, sh, dw, dh);
      no_idle = (ph == 5);
      if (ph == 9) hold_go = 1'b1;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(9) < 3) begin
          add_load(rand_chan(), rand_chan(), rand_chan());
        end else if ($urandom_range(4) == 0 || dw == 0 || dh == 0) begin
          add_request($urandom, $urandom);
        end else begin
          add_request($urandom_range(dw - 1), $urandom_range(dh - 1));
        end
      end
    end
    no_idle = 1'b0;

    while (pending_items.size() > 0 || expected_pixels.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d size settings with %0d pixel loads and %0d interpolation requests,",
             n_phases, n_loads, n_requests);
    $display("checked %0d output pixels, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/bir_pkg.sv
hw/rtl/bir_if.sv
hw/rtl/bir_ctrl.sv
hw/rtl/bir_datapath.sv
hw/rtl/bilinear_image_rescaler_core.sv
tb/sv/tb_bilinear_image_rescaler_core.sv
